/* hdl/refcounted_lru_object_cache_core_macros.svh */
// Assertion helpers
`ifndef REFCOUNTED_LRU_OBJECT_CACHE_CORE_MACROS_SVH
`define REFCOUNTED_LRU_OBJECT_CACHE_CORE_MACROS_SVH
`define RLOC_ASSERT_IMP(label, clk, rst_n, a, c) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) \
        else $error("assertion failed");
`define RLOC_ASSERT_NXT(label, clk, rst_n, a, c) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) \
        else $error("assertion failed");
`endif

/* hdl/rloc_pkg.sv */
package rloc_pkg;
    localparam int ENTRIES_DEF = 64;
    localparam int COUNT_BITS_DEF = 8;
    localparam int DEV_W = 16;
    localparam int NUM_W = 32;
    localparam int SLOT_W = 6;

    typedef enum logic [2:0] {
        OP_GET = 3'd0, OP_GRAB = 3'd1, OP_PUT = 3'd2, OP_RELEASE = 3'd3,
        OP_LOCK = 3'd4, OP_UNLOCK = 3'd5, OP_FLUSH = 3'd6, OP_NONE = 3'd7
    } op_t;

    typedef enum logic [2:0] {
        ST_HIT = 3'd0, ST_MISS = 3'd1, ST_FULL = 3'd2, ST_BUSY = 3'd3,
        ST_NOTLOCKED = 3'd4, ST_FLUSHBUSY = 3'd5, ST_DONE = 3'd6, ST_SAT = 3'd7
    } status_t;

    typedef enum logic [3:0] {
        S_IDLE, S_SCAN_RD, S_SCAN, S_SLOT_RD, S_SLOT, S_LINK_RD, S_LINK,
        S_APPEND, S_RESP
    } state_t;
endpackage

/* hdl/rloc_ram.sv */
module rloc_ram #(
    parameter int DEPTH = 64,
    parameter int WIDTH = 8
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
            mem[waddr] <= wdata;
        rdata <= mem[raddr];
    end
endmodule

/* hdl/refcounted_lru_object_cache_core.sv */
// channel | signals                                          | dir
// request | valid, stall, opcode, device, object_number, slot_index | in
// result  | out_valid, out_stall, status, slot, wake_waiters | out
// Get and flush scan the slots through the entry memory; get stops at a match, flush at a busy entry.
// Slot operations read the entry, then may fix the links or append at the tail.
// Out-of-range slot or unused opcode: straight to the response state.
// After reset a clearing pass over all ENTRIES entries rebuilds the memories; no
// request is taken meanwhile. The result register holds under out_stall.
module refcounted_lru_object_cache_core
    import rloc_pkg::*;
#(
    parameter int ENTRIES = ENTRIES_DEF,
    parameter int COUNT_BITS = COUNT_BITS_DEF
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              valid,
    output logic              stall,
    input  logic [2:0]        opcode,
    input  logic [DEV_W-1:0]  device,
    input  logic [NUM_W-1:0]  object_number,
    input  logic [SLOT_W-1:0] slot_index,
    output logic              out_valid,
    input  logic              out_stall,
    output logic [2:0]        status,
    output logic [SLOT_W-1:0] slot,
    output logic              wake_waiters
);
    localparam int AW = $clog2(ENTRIES);
    localparam int CW = COUNT_BITS;
    localparam logic [CW-1:0] CMAX = {CW{1'b1}};
    localparam logic [AW-1:0] LAST = AW'(ENTRIES - 1);
    // entry word: valid, locked, want, onlist, count, device, number
    localparam int EW = 4 + CW + DEV_W + NUM_W;
    localparam int LW = 2 * AW;

    typedef struct packed {
        logic           vld;
        logic           lck;
        logic           wnt;
        logic           onl;
        logic [CW-1:0]  cnt;
        logic [DEV_W-1:0] dev;
        logic [NUM_W-1:0] num;
    } entry_t;

    state_t state_reg, state_next;
    logic init_reg, init_next;
    logic [AW-1:0] idx_reg, idx_next;
    op_t op_reg, op_next;
    logic [DEV_W-1:0] dev_reg, dev_next;
    logic [NUM_W-1:0] num_reg, num_next;
    logic [AW-1:0] s_reg, s_next;
    logic found_reg, found_next;
    logic [AW-1:0] head_reg, head_next, tail_reg, tail_next;
    logic empty_reg, empty_next;
    logic ov_reg, ov_next;
    logic [2:0] st_reg, st_next;
    logic [SLOT_W-1:0] sl_reg, sl_next;
    logic wk_reg, wk_next;
    logic append_reg, append_next;
    logic [LW-1:0] lk_save_reg, lk_save_next;

    logic e_we, l_we;
    logic [AW-1:0] e_wa, e_ra, l_wa, l_ra;
    entry_t e_wd, e_rd;
    logic [EW-1:0] e_rdv;
    logic [LW-1:0] l_wd, l_rd;
    logic [AW-1:0] l_nx, l_pv;

    rloc_ram #(.DEPTH(ENTRIES), .WIDTH(EW)) u_entry (
        .clk(clk), .we(e_we), .waddr(e_wa), .wdata(e_wd), .raddr(e_ra),
        .rdata(e_rdv));
    rloc_ram #(.DEPTH(ENTRIES), .WIDTH(LW)) u_link (
        .clk(clk), .we(l_we), .waddr(l_wa), .wdata(l_wd), .raddr(l_ra),
        .rdata(l_rd));

    assign e_rd = entry_t'(e_rdv);
    assign l_nx = l_rd[LW-1:AW];
    assign l_pv = l_rd[AW-1:0];

    assign stall = (state_reg != S_IDLE) || init_reg || ov_reg;
    assign out_valid = ov_reg;
    assign status = st_reg;
    assign slot = sl_reg;
    assign wake_waiters = wk_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            init_reg <= 1'b1;
            idx_reg <= '0;
            head_reg <= '0;
            tail_reg <= LAST;
            empty_reg <= 1'b0;
            ov_reg <= 1'b0;
            append_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            init_reg <= init_next;
            idx_reg <= idx_next;
            head_reg <= head_next;
            tail_reg <= tail_next;
            empty_reg <= empty_next;
            ov_reg <= ov_next;
            append_reg <= append_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg <= op_next;
        dev_reg <= dev_next;
        num_reg <= num_next;
        s_reg <= s_next;
        found_reg <= found_next;
        st_reg <= st_next;
        sl_reg <= sl_next;
        wk_reg <= wk_next;
        lk_save_reg <= lk_save_next;
    end

    always_comb
    begin
        entry_t ne;
        logic dorm;
        state_next = state_reg;
        init_next = init_reg;
        idx_next = idx_reg;
        op_next = op_reg;
        dev_next = dev_reg;
        num_next = num_reg;
        s_next = s_reg;
        found_next = found_reg;
        head_next = head_reg;
        tail_next = tail_reg;
        empty_next = empty_reg;
        ov_next = ov_reg && out_stall;
        st_next = st_reg;
        sl_next = sl_reg;
        wk_next = wk_reg;
        append_next = append_reg;
        lk_save_next = lk_save_reg;
        e_we = 1'b0;
        e_wa = s_reg;
        e_wd = e_rd;
        e_ra = idx_reg;
        l_we = 1'b0;
        l_wa = s_reg;
        l_wd = l_rd;
        l_ra = s_reg;
        ne = e_rd;
        dorm = 1'b0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (init_reg)
                begin
                    e_we = 1'b1;
                    e_wa = idx_reg;
                    e_wd = '0;
                    e_wd.onl = 1'b1;
                    l_we = 1'b1;
                    l_wa = idx_reg;
                    l_wd = {(idx_reg == LAST) ? AW'(0) : idx_reg + 1'b1,
                            (idx_reg == AW'(0)) ? LAST : idx_reg - 1'b1};
                    idx_next = idx_reg + 1'b1;
                    if (idx_reg == LAST)
                    begin
                        init_next = 1'b0;
                        idx_next = '0;
                    end
                end
                else if (valid && !ov_reg)
                begin
                    op_next = op_t'(opcode);
                    dev_next = device;
                    num_next = object_number;
                    s_next = AW'(slot_index);
                    found_next = 1'b0;
                    idx_next = '0;
                    append_next = 1'b0;
                    st_next = ST_DONE;
                    sl_next = '0;
                    wk_next = 1'b0;
                    unique case (op_t'(opcode)) inside
                        OP_GET, OP_FLUSH: state_next = S_SCAN_RD;
                        OP_NONE: state_next = S_RESP;
                        default:
                            state_next = (32'(slot_index) < ENTRIES) ? S_SLOT_RD : S_RESP;
                    endcase
                end
            end
            S_SCAN_RD:
            begin
                e_ra = idx_reg;
                state_next = S_SCAN;
            end
            S_SCAN:
            begin
                e_ra = idx_reg + 1'b1;
                if (op_reg == OP_GET)
                begin
                    if (e_rd.vld && e_rd.dev == dev_reg && e_rd.num == num_reg)
                    begin
                        found_next = 1'b1;
                        s_next = idx_reg;
                        e_ra = idx_reg;
                        state_next = S_SLOT_RD;
                    end
                    else if (idx_reg == LAST)
                    begin
                        if (empty_reg)
                        begin
                            st_next = ST_FULL;
                            state_next = S_RESP;
                        end
                        else
                        begin
                            s_next = head_reg;
                            e_ra = head_reg;
                            state_next = S_SLOT_RD;
                        end
                    end
                    else
                        idx_next = idx_reg + 1'b1;
                end
                else
                begin
                    if (e_rd.dev == dev_reg && e_rd.cnt != '0)
                    begin
                        st_next = ST_FLUSHBUSY;
                        sl_next = SLOT_W'(idx_reg);
                        state_next = S_RESP;
                    end
                    else
                    begin
                        if (e_rd.dev == dev_reg)
                        begin
                            e_we = 1'b1;
                            e_wa = idx_reg;
                            e_wd = e_rd;
                            e_wd.vld = 1'b0;
                        end
                        if (idx_reg == LAST)
                            state_next = S_RESP;
                        else
                            idx_next = idx_reg + 1'b1;
                    end
                end
            end
            S_SLOT_RD:
            begin
                e_ra = s_reg;
                l_ra = s_reg;
                state_next = S_SLOT;
            end
            S_SLOT:
            begin
                // e_rd / l_rd hold entry s and its links
                sl_next = SLOT_W'(s_reg);
                lk_save_next = l_rd;
                e_we = 1'b1;
                e_wa = s_reg;
                unique case (op_reg) inside
                    OP_GET, OP_GRAB:
                    begin
                        if (op_reg == OP_GET && !found_reg)
                        begin
                            ne.vld = 1'b1;
                            ne.dev = dev_reg;
                            ne.num = num_reg;
                            ne.lck = 1'b1;
                            ne.wnt = 1'b0;
                            ne.cnt = CW'(1);
                            st_next = ST_MISS;
                            dorm = 1'b1;
                        end
                        else if (e_rd.lck)
                        begin
                            ne.wnt = 1'b1;
                            st_next = ST_BUSY;
                        end
                        else
                        begin
                            dorm = 1'b1;
                            st_next = (op_reg == OP_GET) ? ST_HIT : ST_DONE;
                            if (e_rd.cnt == CMAX)
                                st_next = ST_SAT;
                            else
                                ne.cnt = e_rd.cnt + 1'b1;
                            ne.lck = 1'b1;
                        end
                    end
                    OP_PUT, OP_RELEASE:
                    begin
                        if (op_reg == OP_PUT && !e_rd.lck)
                            st_next = ST_NOTLOCKED;
                        else
                        begin
                            if (op_reg == OP_PUT)
                            begin
                                wk_next = e_rd.wnt;
                                ne.lck = 1'b0;
                                ne.wnt = 1'b0;
                            end
                            if (e_rd.cnt != '0)
                            begin
                                if (e_rd.cnt == CW'(1))
                                begin
                                    wk_next = (op_reg == OP_PUT) ? e_rd.wnt
                                              : e_rd.wnt;
                                    ne.lck = 1'b0;
                                    ne.wnt = 1'b0;
                                    if (!e_rd.onl)
                                    begin
                                        ne.onl = 1'b1;
                                        append_next = 1'b1;
                                    end
                                end
                                ne.cnt = e_rd.cnt - 1'b1;
                            end
                        end
                    end
                    OP_LOCK:
                    begin
                        if (e_rd.lck)
                        begin
                            ne.wnt = 1'b1;
                            st_next = ST_BUSY;
                        end
                        else
                            ne.lck = 1'b1;
                    end
                    default:
                    begin
                        if (!e_rd.lck)
                            st_next = ST_NOTLOCKED;
                        else
                        begin
                            wk_next = e_rd.wnt;
                            ne.lck = 1'b0;
                            ne.wnt = 1'b0;
                        end
                    end
                endcase
                if (dorm && e_rd.onl)
                begin
                    ne.onl = 1'b0;
                    if (s_reg == head_reg && s_reg == tail_reg)
                    begin
                        empty_next = 1'b1;
                        state_next = S_RESP;
                    end
                    else if (s_reg == head_reg)
                    begin
                        head_next = l_nx;
                        state_next = S_RESP;
                    end
                    else if (s_reg == tail_reg)
                    begin
                        tail_next = l_pv;
                        state_next = S_RESP;
                    end
                    else
                    begin
                        l_we = 1'b0;
                        l_ra = l_pv;
                        state_next = S_LINK_RD;
                    end
                end
                else if (append_next)
                    state_next = S_APPEND;
                else
                    state_next = S_RESP;
                e_wd = ne;
            end
            S_LINK_RD:
            begin
                // l_rd now holds links of prev; set prev.next = s.next
                l_we = 1'b1;
                l_wa = lk_save_reg[AW-1:0];
                l_wd = {lk_save_reg[LW-1:AW], l_rd[AW-1:0]};
                l_ra = lk_save_reg[LW-1:AW];
                state_next = S_LINK;
            end
            S_LINK:
            begin
                // l_rd holds links of next; set next.prev = s.prev
                l_we = 1'b1;
                l_wa = lk_save_reg[LW-1:AW];
                l_wd = {l_rd[LW-1:AW], lk_save_reg[AW-1:0]};
                state_next = S_RESP;
            end
            S_APPEND:
            begin
                state_next = S_RESP;
                if (empty_reg)
                begin
                    head_next = s_reg;
                    tail_next = s_reg;
                    empty_next = 1'b0;
                end
                else
                begin
                    state_next = S_LINK_RD;
                    l_ra = tail_reg;
                    l_we = 1'b1;
                    l_wa = s_reg;
                    l_wd = {lk_save_reg[LW-1:AW], tail_reg};
                    lk_save_next = {s_reg, tail_reg};
                    tail_next = s_reg;
                    state_next = S_LINK;
                end
            end
            S_RESP:
            begin
                ov_next = 1'b1;
                state_next = S_IDLE;
            end
            default: state_next = S_IDLE;
        endcase

        // append: in S_LINK after S_APPEND write tail.next = s
        if (state_reg == S_LINK && append_reg)
        begin
            l_wa = lk_save_reg[AW-1:0];
            l_wd = {lk_save_reg[LW-1:AW], l_rd[AW-1:0]};
            append_next = 1'b0;
        end
    end
endmodule

/* hdl/rloc_checker.sv */
`include "refcounted_lru_object_cache_core_macros.svh"
module rloc_checker
    import rloc_pkg::*;
(
    input logic       clk,
    input logic       rst_n,
    input logic       valid,
    input logic       stall,
    input logic       out_valid,
    input logic       out_stall,
    input logic [2:0] status,
    input logic       wake_waiters
);
    `RLOC_ASSERT_NXT(a_hold, clk, rst_n, out_valid && out_stall, out_valid && $stable(status))
    `RLOC_ASSERT_IMP(a_nowork, clk, rst_n, out_valid, stall)
    `RLOC_ASSERT_NXT(a_accept, clk, rst_n, valid && !stall, stall)
    `RLOC_ASSERT_IMP(a_wake, clk, rst_n, out_valid && wake_waiters, status == ST_DONE)
endmodule

bind refcounted_lru_object_cache_core rloc_checker u_rloc_checker (
    .clk(clk), .rst_n(rst_n), .valid(valid), .stall(stall),
    .out_valid(out_valid), .out_stall(out_stall), .status(status),
    .wake_waiters(wake_waiters));
